/* rtl/core/dsks_pkg.sv */
// Package for the draw state key sorter: widths, register map, cell and
// read-stage types, controller states. No dependencies.
package dsks_pkg;

  // queue geometry
  localparam int QUEUE_DEPTH = 64;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);

  // field widths
  localparam int PIPE_W   = 64;
  localparam int DESC_W   = 64;
  localparam int LAYOUT_W = 32;
  localparam int TAG_W    = 32;
  localparam int CNT_W    = 32;
  localparam int KEY_W    = PIPE_W + DESC_W + LAYOUT_W;

  // APB register map: one 32-bit register, word index taken from paddr[2]
  localparam int   APB_ADDR_W = 3;
  localparam int   APB_DATA_W = 32;
  localparam logic REG_BLEND  = 1'b0;

  // one sorter cell: composite key plus the arrival slot of the draw
  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
  } cell_t;

  // chain-wide control, same for every cell
  typedef struct packed {
    logic ins;    // insert the incoming key this cycle
    logic shift;  // move every entry one cell toward the head
  } cell_ctl_t;

  // registered memory read, handed to the output stage
  typedef struct packed {
    logic [PIPE_W-1:0]   pipe;
    logic [DESC_W-1:0]   desc;
    logic [LAYOUT_W-1:0] layout;
    logic [TAG_W-1:0]    tag;
    logic                first;
    logic                last;
  } rd_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

endpackage

/* rtl/core/dsks_if.sv */
// Valid/ready channel interfaces for draw commands in and sorted draws out.
// Depends on dsks_pkg.
interface dsks_in_if;
  import dsks_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIPE_W-1:0]   pipe_hash;
  logic [DESC_W-1:0]   descriptor_hash;
  logic [LAYOUT_W-1:0] layout_id;
  logic [TAG_W-1:0]    draw_tag;
  logic                end_of_pass;

  modport source (
    output valid, pipe_hash, descriptor_hash, layout_id, draw_tag, end_of_pass,
    input  ready
  );
  modport sink (
    input  valid, pipe_hash, descriptor_hash, layout_id, draw_tag, end_of_pass,
    output ready
  );
endinterface

interface dsks_out_if;
  import dsks_pkg::*;

  logic                valid;
  logic                ready;
  logic [PIPE_W-1:0]   out_pipe_hash;
  logic [DESC_W-1:0]   out_descriptor_hash;
  logic [LAYOUT_W-1:0] out_layout_id;
  logic [TAG_W-1:0]    out_draw_tag;
  logic                switch_avoided;
  logic [CNT_W-1:0]    avoided_total;
  logic                last_in_run;

  modport source (
    output valid, out_pipe_hash, out_descriptor_hash, out_layout_id, out_draw_tag,
           switch_avoided, avoided_total, last_in_run,
    input  ready
  );
  modport sink (
    input  valid, out_pipe_hash, out_descriptor_hash, out_layout_id, out_draw_tag,
           switch_avoided, avoided_total, last_in_run,
    output ready
  );
endinterface

/* rtl/core/dsks_cell.sv */
// One cell of the sorted insertion chain. Holds one key and arrival slot.
// Depends on dsks_pkg.
module dsks_cell (
  input  logic                     clk,
  input  logic                     rst,
  input  dsks_pkg::cell_ctl_t      ctl,
  input  logic [dsks_pkg::KEY_W-1:0] new_key,
  input  logic [dsks_pkg::IDX_W-1:0] new_idx,
  input  dsks_pkg::cell_t          left,
  input  logic                     left_lt,
  input  dsks_pkg::cell_t          right,
  output dsks_pkg::cell_t          cur,
  output logic                     lt
);
  import dsks_pkg::*;

  cell_t cur_next;
  logic  load;

  // empty cells sort last; strict compare keeps equal keys in arrival order
  assign lt = !cur.valid || (new_key < cur.key);

  // insert: first cell past the new key takes it, cells behind take the left one
  always_comb begin
    cur_next = cur;
    load     = 1'b0;
    if (ctl.ins && lt) begin
      load     = 1'b1;
      cur_next = left_lt ? left : cell_t'{valid: 1'b1, key: new_key, idx: new_idx};
    end else if (ctl.shift) begin
      load     = 1'b1;
      cur_next = right;
    end
  end

  // valid clears on reset; key and slot just follow the load
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else if (load) begin
      cur.valid <= cur_next.valid;
    end
    if (load) begin
      cur.key <= cur_next.key;
      cur.idx <= cur_next.idx;
    end
  end

endmodule

/* rtl/core/dsks_out.sv */
// Output stage: switch-avoided flag, saturating counter, result register.
// Depends on dsks_pkg and dsks_out_if.
module dsks_out (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_valid,
  input  dsks_pkg::rd_t rd,
  output logic          take,
  dsks_out_if.source    res
);
  import dsks_pkg::*;

  logic [PIPE_W-1:0] prev_pipe;
  logic [DESC_W-1:0] prev_desc;
  logic [PIPE_W-1:0] cmp_pipe;
  logic              flag;
  logic [CNT_W-1:0]  avoided;
  logic [CNT_W-1:0]  avoided_next;

  assign take = rd_valid && (!res.valid || res.ready);

  // previous draw counts as zero at the start of each flush
  assign cmp_pipe = rd.first ? '0 : prev_pipe;
  assign flag     = (cmp_pipe != '0) && (cmp_pipe == rd.pipe) && (prev_desc == rd.desc);

  assign avoided_next = (flag && (avoided != '1)) ? avoided + 1'b1 : avoided;

  // control and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
      avoided   <= '0;
    end else begin
      if (take) begin
        res.valid <= 1'b1;
        avoided   <= avoided_next;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      prev_pipe               <= rd.pipe;
      prev_desc               <= rd.desc;
      res.out_pipe_hash       <= rd.pipe;
      res.out_descriptor_hash <= rd.desc;
      res.out_layout_id       <= rd.layout;
      res.out_draw_tag        <= rd.tag;
      res.switch_avoided      <= flag;
      res.avoided_total       <= avoided_next;
      res.last_in_run         <= rd.last;
    end
  end

endmodule

/* rtl/core/draw_state_key_sorter_unit.sv */
// Draw state key sorter top level: insertion chain, draw memory, drain control.
// Depends on dsks_pkg, dsks_if, dsks_cell, dsks_out.
// Fill: one draw per cycle enters the chain of cells, which keeps the pass sorted.
// Flush: the flushing transfer starts the drain; reads go via the read register to the
// result register, one per cycle while res.ready allows; cmd stalls until the last read.
// Reset (synchronous): chain and queue empty, counter zero, blending off; no clear pass.
module draw_state_key_sorter_unit (
  input  logic                            clk,
  input  logic                            rst,
  dsks_in_if.sink                         cmd,
  dsks_out_if.source                      res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [dsks_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [dsks_pkg::APB_DATA_W-1:0] pwdata,
  output logic [dsks_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import dsks_pkg::*;

  localparam int MEM_W = PIPE_W + DESC_W + LAYOUT_W + TAG_W;

  state_t            state;
  logic              blending;
  logic              blend_run;
  logic [IDX_W-1:0]  count;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  issue_k;
  logic [IDX_W-1:0]  rd_addr;
  logic              in_xfer;
  logic              flush;
  logic              issue;
  logic              issue_last;
  logic              rd_valid;
  logic              rd_first;
  logic              rd_last;
  logic              take;
  rd_t               rd;
  cell_ctl_t         ctl;
  logic [KEY_W-1:0]  new_key;
  logic [MEM_W-1:0]  mem [QUEUE_DEPTH];
  logic [MEM_W-1:0]  mem_q;
  cell_t             cell_q  [QUEUE_DEPTH];
  logic              cell_lt [QUEUE_DEPTH];

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLEND) ? APB_DATA_W'(blending) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      blending <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_BLEND) begin
      blending <= pwdata[0];
    end
  end

  // input side
  assign cmd.ready = (state == ST_FILL);
  assign in_xfer   = cmd.valid && cmd.ready;
  assign flush     = in_xfer && (cmd.end_of_pass || count == IDX_W'(QUEUE_DEPTH - 1));
  assign new_key   = {cmd.pipe_hash, cmd.descriptor_hash, cmd.layout_id};

  // drain side: one read per cycle while the read register can move on
  assign issue      = (state == ST_DRAIN) && (!rd_valid || take);
  assign issue_last = (issue_k == last_idx);
  assign rd_addr    = blend_run ? issue_k : cell_q[0].idx;

  assign ctl = '{ins: in_xfer, shift: issue};

  // insertion chain
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    dsks_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .new_key (new_key),
      .new_idx (count),
      .left    ((i == 0) ? cell_t'('0) : cell_q[(i == 0) ? 0 : i - 1]),
      .left_lt ((i == 0) ? 1'b0 : cell_lt[(i == 0) ? 0 : i - 1]),
      .right   ((i == QUEUE_DEPTH - 1) ? cell_t'('0) :
                cell_q[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .cur     (cell_q[i]),
      .lt      (cell_lt[i])
    );
  end

  // draw memory in arrival order
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      mem[count] <= {cmd.pipe_hash, cmd.descriptor_hash, cmd.layout_id, cmd.draw_tag};
    end
    if (issue) begin
      mem_q <= mem[rd_addr];
    end
  end

  // read stage flags ride with the memory data
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_first <= (issue_k == '0);
      rd_last  <= issue_last;
    end
  end

  assign rd = '{pipe:   mem_q[MEM_W-1 -: PIPE_W],
                desc:   mem_q[MEM_W-PIPE_W-1 -: DESC_W],
                layout: mem_q[TAG_W +: LAYOUT_W],
                tag:    mem_q[TAG_W-1:0],
                first:  rd_first,
                last:   rd_last};

  // controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_FILL;
      count    <= '0;
      issue_k  <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (take) begin
        rd_valid <= 1'b0;
      end
      case (state)
        ST_FILL: begin
          if (in_xfer) begin
            count <= flush ? '0 : count + 1'b1;
          end
          if (flush) begin
            state   <= ST_DRAIN;
            issue_k <= '0;
          end
        end
        ST_DRAIN: begin
          if (issue) begin
            issue_k <= issue_k + 1'b1;
            if (issue_last) begin
              state <= ST_FILL;
            end
          end
        end
        default: begin
          state <= ST_FILL;
        end
      endcase
    end
  end

  // values latched at the flush
  always_ff @(posedge clk) begin
    if (flush) begin
      last_idx  <= count;
      blend_run <= blending;
    end
  end

  dsks_out u_out (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd       (rd),
    .take     (take),
    .res      (res)
  );

  // chain holds an entry for every read still to issue
  a_drain_has_entry: assert property (@(posedge clk) disable iff (rst)
    state == ST_DRAIN |-> cell_q[0].valid)
    else $error("drain with empty chain");

  // chain is empty once the last read of a flush has issued
  a_drain_empties: assert property (@(posedge clk) disable iff (rst)
    issue && issue_last |=> !cell_q[0].valid)
    else $error("chain not empty after drain");

  // occupied cells form a prefix of the chain; checked at the head: cell 1 needs cell 0
  a_chain_prefix: assert property (@(posedge clk) disable iff (rst)
    cell_q[1].valid |-> cell_q[0].valid)
    else $error("gap at head of chain");

  // a draw that does not flush grows the queue by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !flush |=> state == ST_FILL && count == $past(count) + 1'b1)
    else $error("queue count off");

endmodule

/* sim/tb_draw_state_key_sorter_unit.sv */
`timescale 1ns / 100ps
// Testbench for draw_state_key_sorter_unit: draws pass by pass, APB writes of
// the blend register, a scoreboard that buffers each pass and sorts it unless blending.
// Depends on dsks_pkg, dsks_if and the RTL of the block.
import dsks_pkg::*;

localparam logic [APB_ADDR_W-1:0] BLEND_ADDR = {REG_BLEND, 2'b00};
localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_BLEND, 2'b00};

// one draw command as sent
typedef struct packed {
  logic [PIPE_W-1:0]   pipe;
  logic [DESC_W-1:0]   desc;
  logic [LAYOUT_W-1:0] layout;
  logic [TAG_W-1:0]    tag;
  logic                eop;
} draw_t;

// one emitted draw
typedef struct packed {
  logic [PIPE_W-1:0]   pipe;
  logic [DESC_W-1:0]   desc;
  logic [LAYOUT_W-1:0] layout;
  logic [TAG_W-1:0]    tag;
  logic                avoided;
  logic [CNT_W-1:0]    total;
  logic                last_flag;
} sorted_draw_t;

// Buffers the open pass, orders it on a flush and keeps the emitted draws due.
class draw_order_board;
  draw_t          pass_q[$];
  sorted_draw_t   due_q[$];
  logic           blending = 1'b0;
  logic [CNT_W-1:0] avoided_sum = '0;
  int             mismatches = 0;

  task flag_mismatch(string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  function void note_reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    if (addr == BLEND_ADDR) blending = data[0];
  endfunction

  function logic [KEY_W-1:0] sort_key(draw_t d);
    return {d.pipe, d.desc, d.layout};
  endfunction

  // accepted draw: buffer it, flush on end of pass or full queue
  function void note_draw(draw_t d);
    draw_t        held;
    sorted_draw_t o;
    int           j;
    logic [PIPE_W-1:0] prev_pipe;
    logic [DESC_W-1:0] prev_desc;
    pass_q = {pass_q, d};
    if (!d.eop && pass_q.size() < QUEUE_DEPTH) return;
    // stable insertion sort unless blending keeps arrival order
    if (!blending) begin
      for (int i = 1; i < pass_q.size(); i++) begin
        held = pass_q[i];
        j = i;
        while (j > 0 && sort_key(held) < sort_key(pass_q[j-1])) begin
          pass_q[j] = pass_q[j-1];
          j--;
        end
        pass_q[j] = held;
      end
    end
    prev_pipe = '0;
    prev_desc = '0;
    for (int k = 0; k < pass_q.size(); k++) begin
      o.pipe      = pass_q[k].pipe;
      o.desc      = pass_q[k].desc;
      o.layout    = pass_q[k].layout;
      o.tag       = pass_q[k].tag;
      o.avoided   = (prev_pipe != '0) && (prev_pipe == o.pipe) && (prev_desc == o.desc);
      if (o.avoided && avoided_sum != '1) avoided_sum++;
      o.total     = avoided_sum;
      o.last_flag = (k == pass_q.size() - 1);
      prev_pipe   = o.pipe;
      prev_desc   = o.desc;
      due_q = {due_q, o};
    end
    pass_q.delete();
  endfunction

  function int pending();
    return due_q.size();
  endfunction

  task check_result(sorted_draw_t got);
    sorted_draw_t want;
    if (due_q.size() == 0) begin
      flag_mismatch($sformatf("unexpected draw tag %h", got.tag));
      return;
    end
    want = due_q.pop_front();
    if (got.pipe !== want.pipe)
      flag_mismatch($sformatf("pipeline %h, want %h", got.pipe, want.pipe));
    if (got.desc !== want.desc)
      flag_mismatch($sformatf("descriptor %h, want %h", got.desc, want.desc));
    if (got.layout !== want.layout)
      flag_mismatch($sformatf("layout %h, want %h", got.layout, want.layout));
    if (got.tag !== want.tag)
      flag_mismatch($sformatf("tag %h, want %h", got.tag, want.tag));
    if (got.avoided !== want.avoided)
      flag_mismatch($sformatf("switch_avoided %b, want %b (tag %h)",
                              got.avoided, want.avoided, want.tag));
    if (got.total !== want.total)
      flag_mismatch($sformatf("avoided_total %0d, want %0d", got.total, want.total));
    if (got.last_flag !== want.last_flag)
      flag_mismatch($sformatf("last_in_run %b, want %b (tag %h)",
                              got.last_flag, want.last_flag, want.tag));
  endtask
endclass

module tb_draw_state_key_sorter_unit;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_SLACK = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  dsks_in_if  cmd_if ();
  dsks_out_if res_if ();

  draw_order_board board = new();

  int   cycle_count = 0;
  int   stall_left = 0;
  bit   steady = 1'b0;
  logic [PIPE_W-1:0]   pipe_pool[4];
  logic [DESC_W-1:0]   desc_pool[4];
  logic [LAYOUT_W-1:0] layout_pool[3];

  draw_state_key_sorter_unit dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: ready with random stalls, none in steady stretches
  initial begin
    int r;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        res_if.ready <= 1'b1;
      end else if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          res_if.ready <= 1'b1;
        end else begin
          res_if.ready <= 1'b0;
          stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  // check every result transfer
  always @(posedge clk) begin : result_monitor
    sorted_draw_t got;
    if (!rst && res_if.valid && res_if.ready) begin
      got.pipe      = res_if.out_pipe_hash;
      got.desc      = res_if.out_descriptor_hash;
      got.layout    = res_if.out_layout_id;
      got.tag       = res_if.out_draw_tag;
      got.avoided   = res_if.switch_avoided;
      got.total     = res_if.avoided_total;
      got.last_flag = res_if.last_in_run;
      board.check_result(got);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic draw_t mk(logic [63:0] p, logic [63:0] d, logic [31:0] l,
                               logic [31:0] t, logic e);
    draw_t x;
    x.pipe = p;
    x.desc = d;
    x.layout = l;
    x.tag = t;
    x.eop = e;
    return x;
  endfunction

  // keys mostly from small pools so that ties and repeats are common
  function automatic draw_t rand_draw(logic e);
    logic [63:0] p;
    logic [63:0] d;
    logic [31:0] l;
    p = ($urandom_range(0, 9) < 8) ? pipe_pool[$urandom_range(0, 3)] : rand64();
    d = ($urandom_range(0, 9) < 8) ? desc_pool[$urandom_range(0, 3)] : rand64();
    l = ($urandom_range(0, 9) < 7) ? layout_pool[$urandom_range(0, 2)] : $urandom();
    return mk(p, d, l, $urandom(), e);
  endfunction

  function automatic void refresh_pools();
    for (int i = 0; i < 4; i++) begin
      pipe_pool[i] = rand64();
      desc_pool[i] = ($urandom_range(0, 3) == 0) ? 64'd0 : rand64();
    end
    if ($urandom_range(0, 1)) pipe_pool[0] = '0;
    for (int i = 0; i < 3; i++) layout_pool[i] = $urandom_range(0, 7);
  endfunction

  // one draw transfer after an optional gap
  task send_draw(draw_t d, int gap);
    if (gap > 0) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd_if.valid           <= 1'b1;
    cmd_if.pipe_hash       <= d.pipe;
    cmd_if.descriptor_hash <= d.desc;
    cmd_if.layout_id       <= d.layout;
    cmd_if.draw_tag        <= d.tag;
    cmd_if.end_of_pass     <= d.eop;
    do @(posedge clk); while (!cmd_if.ready);
    board.note_draw(d);
  endtask

  // hold the sender until every due draw has come out
  task wait_drained();
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // APB transfer: setup then access, done when pready is high
  task apb_access(logic wr, logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data,
                  output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr) board.note_reg_write(addr, data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // blend write on an idle block, read back
  task set_blending(logic blend);
    logic [APB_DATA_W-1:0] rd;
    wait_drained();
    apb_access(1'b1, BLEND_ADDR, {{(APB_DATA_W-1){1'b0}}, blend}, rd);
    apb_access(1'b0, BLEND_ADDR, '0, rd);
    if (rd[0] !== board.blending)
      board.flag_mismatch($sformatf("blend readback %b, want %b", rd[0], board.blending));
  endtask

  // one pass of random draws; without end flag only on a full-queue length
  task run_pass(int len, logic end_flag);
    refresh_pools();
    for (int k = 0; k < len; k++)
      send_draw(rand_draw((k == len - 1) ? end_flag : 1'b0), pick_gap());
  endtask

  initial begin
    logic [APB_DATA_W-1:0] rd;
    logic [63:0] hi_pipe;
    int len;
    int sent;
    int r;
    logic end_flag;

    cmd_if.valid           = 1'b0;
    cmd_if.pipe_hash       = '0;
    cmd_if.descriptor_hash = '0;
    cmd_if.layout_id       = '0;
    cmd_if.draw_tag        = '0;
    cmd_if.end_of_pass     = 1'b0;
    hi_pipe = 64'h8000_0000_0000_0001;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, flags, zero pipeline, stability, unsigned order
    set_blending(1'b0);
    send_draw(mk('0, '0, '0, '0, 1'b1), 0);
    send_draw(mk('1, '1, '1, '1, 1'b1), 1);
    for (int i = 0; i < 5; i++)
      send_draw(mk(hi_pipe, 64'hDEAD, 5 - i, 32'h10 + i, i == 4), 0);
    for (int i = 0; i < 4; i++)
      send_draw(mk('0, 64'd7, 3 - i, 32'h20 + i, i == 3), pick_gap());
    send_draw(mk(hi_pipe, 64'd1, 32'd9, 32'h30, 1'b0), 0);
    send_draw(mk(64'd1,   64'd1, 32'd9, 32'h31, 1'b0), 0);
    send_draw(mk(hi_pipe, 64'd1, 32'd9, 32'h32, 1'b0), 0);
    send_draw(mk(64'd1,   64'd0, '1,    32'h33, 1'b1), 0);

    // write to an unmapped word is ignored: next pass still sorted
    wait_drained();
    apb_access(1'b1, SPARE_ADDR, 32'hFFFF_FFFF, rd);
    send_draw(mk(64'd5, 64'd2, 32'd0, 32'h40, 1'b0), 0);
    send_draw(mk(64'd3, 64'd2, 32'd0, 32'h41, 1'b1), 0);

    // blending keeps arrival order
    set_blending(1'b1);
    send_draw(mk(64'd9, 64'd4, 32'd1, 32'h50, 1'b0), 0);
    send_draw(mk(64'd9, 64'd4, 32'd0, 32'h51, 1'b0), 0);
    send_draw(mk(64'd2, 64'd4, 32'd0, 32'h52, 1'b0), 0);
    send_draw(mk(64'd9, 64'd4, 32'd0, 32'h53, 1'b1), 0);

    // random phases, blend setting changed between them
    for (int ph = 0; ph < 5; ph++) begin
      set_blending(ph[0]);
      steady = (ph == 2);
      sent = 0;
      while (sent < 68) begin
        end_flag = 1'b1;
        if (sent == 0 && ph == 0) begin
          len = QUEUE_DEPTH;
          end_flag = 1'b0;
        end else if (sent == 0 && ph == 1) begin
          len = QUEUE_DEPTH;
        end else if (sent == 0 && ph == 3) begin
          len = QUEUE_DEPTH + $urandom_range(1, 6);
        end else begin
          r = $urandom_range(0, 99);
          if (r < 75) len = $urandom_range(1, 10);
          else if (r < 95) len = $urandom_range(11, 30);
          else len = $urandom_range(31, 63);
        end
        run_pass(len, end_flag);
        sent += len;
        if ($urandom_range(0, 7) == 0) wait_drained();
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/dsks_pkg.sv
rtl/core/dsks_if.sv
rtl/core/dsks_cell.sv
rtl/core/dsks_out.sv
rtl/core/draw_state_key_sorter_unit.sv
sim/tb_draw_state_key_sorter_unit.sv
